FILE: rtl/core/line_tracking_steering_control_defines.svh
// Assertion macros for the line tracking steering control checker.
`ifndef LINE_TRACKING_STEERING_CONTROL_DEFINES_SVH
`define LINE_TRACKING_STEERING_CONTROL_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define LTSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define LTSC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ltsc_pkg.sv
// Shared types, constants and gain tables for the line tracking steering control.
`timescale 1ns / 1ps
package ltsc_pkg;

  // Parameter defaults
  localparam int NUM_SENSORS_DEF  = 15;
  localparam int TILT_PERIOD_DEF  = 1000;
  localparam int STEER_PERIOD_DEF = 20000;

  // Field widths
  localparam int SENSOR_FRAME_W = 15;
  localparam int LINE_POS_W     = 5;
  localparam int TILT_DUTY_W    = 10;
  localparam int STEER_DUTY_W   = 15;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 15;
  localparam int MAG_W          = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_CENTER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_CENTER = 1'b1;

  // Reset values
  localparam int TILT_CENTER_RST  = 224;
  localparam int STEER_CENTER_RST = 1482;

  // Edge-loss test
  localparam int EDGE_MARGIN   = 3;
  localparam int EDGE_DIFF_MIN = 2;
  localparam int EDGE_SUM_MAX  = 11;

  // Tilt gain bands
  localparam int TILT_GAIN_MAX = 56;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;
    logic scan;
    logic div_init;
    logic div_step;
    logic edge_eval;
    logic tilt_mul;
    logic tilt_upd;
    logic off_calc;
    logic steer_mul;
    logic steer_upd;
    logic out_load;
  } ltsc_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic lost;
  } ltsc_sts_t;

  function automatic logic [5:0] tilt_gain(input logic [MAG_W-1:0] a);
    logic [5:0] g;
    if (a <= 5'd2)       g = 6'd3;
    else if (a <= 5'd4)  g = 6'd11;
    else if (a <= 5'd6)  g = 6'd18;
    else if (a <= 5'd8)  g = 6'd26;
    else if (a <= 5'd10) g = 6'd35;
    else if (a <= 5'd12) g = 6'd45;
    else                 g = 6'(TILT_GAIN_MAX);
    return g;
  endfunction

  function automatic logic [3:0] steer_gain(input logic [MAG_W-1:0] a);
    logic [3:0] g;
    if (a <= 5'd4)      g = 4'd6;
    else if (a <= 5'd8) g = 4'd8;
    else                g = 4'd10;
    return g;
  endfunction

endpackage

FILE: rtl/core/line_tracking_steering_control.sv
// Top level of the line tracking steering control: controller plus datapath.
// Per frame: sensor scan, divide by the hit count, loss test, then the tilt and steering
//   updates and the output load; a lost line goes straight from the loss test to the output.
// One frame at a time: the sensor scan takes one bit a cycle and the divide one quotient
//   bit a cycle, and a new frame is taken only once the previous one is in the output register.
// Reset (rst, synchronous, active high): centers back to 224 / 1482, duties to those
//   values, position, history and previous offset cleared, no result pending.
`timescale 1ns / 1ps
module line_tracking_steering_control import ltsc_pkg::*; #(
  parameter int NUM_SENSORS  = NUM_SENSORS_DEF,
  parameter int TILT_PERIOD  = TILT_PERIOD_DEF,
  parameter int STEER_PERIOD = STEER_PERIOD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // sensor frame requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [14:0] sensor_frame, [15] zero
  // result requests
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [4:0] line_position, [14:5] tilt_duty,
                                           // [29:15] steer_duty, [31:30] zero
  output logic                  m_tuser,   // [0] line_lost
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ltsc_cmd_t               cmd;
  ltsc_sts_t               sts;
  logic [LINE_POS_W-1:0]   line_position;
  logic                    line_lost;
  logic [TILT_DUTY_W-1:0]  tilt_duty;
  logic [STEER_DUTY_W-1:0] steer_duty;

  // Registers are always writable; by contract writes are to land only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  assign m_tdata = {2'b00, steer_duty, tilt_duty, line_position};
  assign m_tuser = line_lost;

  // Sequencer: one frame at a time, result parked in the output register so the
  // next frame can be taken while the previous result waits.
  ltsc_ctrl #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic: hit count and weighted sum, divide, loss test, tilt and steer duties.
  ltsc_datapath #(
    .NUM_SENSORS  (NUM_SENSORS),
    .TILT_PERIOD  (TILT_PERIOD),
    .STEER_PERIOD (STEER_PERIOD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .sensor_frame  (s_tdata[SENSOR_FRAME_W-1:0]),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .line_position (line_position),
    .line_lost     (line_lost),
    .tilt_duty     (tilt_duty),
    .steer_duty    (steer_duty)
  );

endmodule

FILE: rtl/core/ltsc_ctrl.sv
// Sequencer for the line tracking steering control: scan, divide, update, output.
`timescale 1ns / 1ps
module ltsc_ctrl import ltsc_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  ltsc_sts_t sts,
  output ltsc_cmd_t cmd
);

  localparam int SCAN_W = $clog2(NUM_SENSORS);
  localparam int QUO_W  = $clog2(NUM_SENSORS);
  localparam int DIV_W  = $clog2(QUO_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_EDGE,
    ST_TILT_MUL,
    ST_TILT_UPD,
    ST_OFFSET,
    ST_STEER_MUL,
    ST_STEER_UPD,
    ST_OUT
  } state_t;

  state_t            state;
  logic [SCAN_W-1:0] scan_cnt;
  logic [DIV_W-1:0]  div_cnt;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:      cmd.load      = s_tvalid;
      ST_SCAN:      cmd.scan      = 1'b1;
      ST_DIV_INIT:  cmd.div_init  = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_EDGE:      cmd.edge_eval = 1'b1;
      ST_TILT_MUL:  cmd.tilt_mul  = 1'b1;
      ST_TILT_UPD:  cmd.tilt_upd  = 1'b1;
      ST_OFFSET:    cmd.off_calc  = 1'b1;
      ST_STEER_MUL: cmd.steer_mul = 1'b1;
      ST_STEER_UPD: cmd.steer_upd = 1'b1;
      ST_OUT:       cmd.out_load  = out_free;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      div_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_OUT a taken result is replaced by the next one below
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          if (s_tvalid) state <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SCAN_W'(NUM_SENSORS - 1)) state <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_W'(QUO_W - 1)) state <= ST_EDGE;
        end
        ST_EDGE: begin
          if (sts.lost) state <= ST_OUT;
          else          state <= ST_TILT_MUL;
        end
        ST_TILT_MUL:  state <= ST_TILT_UPD;
        ST_TILT_UPD:  state <= ST_OFFSET;
        ST_OFFSET:    state <= ST_STEER_MUL;
        ST_STEER_MUL: state <= ST_STEER_UPD;
        ST_STEER_UPD: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/ltsc_datapath.sv
// Datapath: sensor scan, restoring divide, loss test, tilt and steering duty update.
`timescale 1ns / 1ps
module ltsc_datapath import ltsc_pkg::*; #(
  parameter int NUM_SENSORS  = NUM_SENSORS_DEF,
  parameter int TILT_PERIOD  = TILT_PERIOD_DEF,
  parameter int STEER_PERIOD = STEER_PERIOD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ltsc_cmd_t                cmd,
  output ltsc_sts_t                sts,
  input  logic [SENSOR_FRAME_W-1:0] sensor_frame,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic [LINE_POS_W-1:0]    line_position,
  output logic                     line_lost,
  output logic [TILT_DUTY_W-1:0]   tilt_duty,
  output logic [STEER_DUTY_W-1:0]  steer_duty
);

  localparam int EXT_W     = (NUM_SENSORS > SENSOR_FRAME_W) ? NUM_SENSORS : SENSOR_FRAME_W;
  localparam int CNT_W     = $clog2(NUM_SENSORS + 1);
  localparam int QUO_W     = $clog2(NUM_SENSORS);
  localparam int POS_W     = QUO_W + 1;
  localparam int SUM_W     = $clog2(NUM_SENSORS * NUM_SENSORS) + 1;
  localparam int TILT_MAX  = (TILT_PERIOD > TILT_CENTER_RST) ? TILT_PERIOD : TILT_CENTER_RST;
  localparam int STEER_MAX = (STEER_PERIOD > STEER_CENTER_RST) ? STEER_PERIOD
                                                               : STEER_CENTER_RST;
  localparam int TD_W      = $clog2(TILT_MAX + 1);
  localparam int SD_W      = $clog2(STEER_MAX + 1);
  localparam int STEP_MAX  = TILT_GAIN_MAX * 2 * (NUM_SENSORS - 1);
  localparam int STEP_W    = $clog2(STEP_MAX + 1) + 1;
  localparam int ACC_W     = ((TD_W > STEP_W) ? TD_W : STEP_W) + 2;
  localparam int OFF_W     = ((TD_W > TILT_DUTY_W) ? TD_W : TILT_DUTY_W) + 1;
  localparam int PO_W      = ((OFF_W > POS_W) ? OFF_W : POS_W) + 1;
  localparam int PR_W      = PO_W + 4;
  localparam int DT_W      = OFF_W + 2;
  localparam int SR_W0     = (PR_W > DT_W) ? PR_W : DT_W;
  localparam int SR_W      = ((SR_W0 > STEER_DUTY_W) ? SR_W0 : STEER_DUTY_W) + 2;

  // configuration
  logic [TILT_DUTY_W-1:0]  tilt_center;
  logic [STEER_DUTY_W-1:0] steer_center;

  // scan
  logic [EXT_W-1:0]        frame_ext;
  logic [NUM_SENSORS-1:0]  frame_sr;
  logic signed [SUM_W-1:0] weight;
  logic signed [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0]        hit_cnt;

  // divide
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W-1:0]        rem;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W:0]          trial;

  // position state
  logic signed [POS_W-1:0] last_pos;
  logic signed [POS_W-1:0] hist1;
  logic signed [POS_W-1:0] pos_q;
  logic [POS_W-1:0]        hist_mag;
  logic signed [POS_W:0]   h_diff;
  logic signed [POS_W:0]   h_sum;
  logic [POS_W:0]          h_diff_mag;
  logic [POS_W:0]          h_sum_mag;
  logic                    edge_zone;
  logic                    lost_now;
  logic                    lost_q;
  logic [MAG_W-1:0]        pos_mag;

  // duty state
  logic signed [STEP_W-1:0] tilt_step;
  logic signed [ACC_W-1:0]  tilt_sum;
  logic [TD_W-1:0]          tilt_reg;
  logic [SD_W-1:0]          steer_reg;
  logic signed [OFF_W-1:0]  offset;
  logic signed [OFF_W-1:0]  off_prev;
  logic signed [PO_W-1:0]   pos_off;
  logic signed [PR_W-1:0]   prod;
  logic signed [DT_W-1:0]   dterm;
  logic signed [SR_W-1:0]   steer_raw;

  assign frame_ext = EXT_W'(sensor_frame);
  assign sum_mag   = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
  assign trial     = {rem, quo[QUO_W-1]};

  // loss test against the newest history entry
  assign pos_q      = sum_acc[SUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign hist_mag   = hist1[POS_W-1] ? POS_W'(-hist1) : POS_W'(hist1);
  assign h_diff     = (POS_W+1)'(hist1) - (POS_W+1)'(pos_q);
  assign h_sum      = (POS_W+1)'(hist1) + (POS_W+1)'(pos_q);
  assign h_diff_mag = h_diff[POS_W] ? (POS_W+1)'(-h_diff) : (POS_W+1)'(h_diff);
  assign h_sum_mag  = h_sum[POS_W] ? (POS_W+1)'(-h_sum) : (POS_W+1)'(h_sum);
  assign edge_zone  = (32'(hist_mag) + 32'(EDGE_MARGIN)) >= 32'(NUM_SENSORS - 1);
  assign lost_now   = (hit_cnt == '0) ||
                      (edge_zone && (32'(h_diff_mag) > 32'(EDGE_DIFF_MIN)) &&
                       (32'(h_sum_mag) <= 32'(EDGE_SUM_MAX)));
  assign sts.lost   = lost_now;

  assign pos_mag  = MAG_W'(last_pos[POS_W-1] ? POS_W'(-last_pos) : POS_W'(last_pos));
  assign tilt_sum = ACC_W'($signed({1'b0, tilt_reg})) + ACC_W'(tilt_step);
  assign pos_off  = PO_W'(last_pos) + PO_W'(offset);
  assign steer_raw = SR_W'($signed({1'b0, steer_center})) - SR_W'(prod) - SR_W'(dterm);

  // state that reset sets
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_center  <= TILT_DUTY_W'(TILT_CENTER_RST);
      steer_center <= STEER_DUTY_W'(STEER_CENTER_RST);
      last_pos     <= '0;
      hist1        <= '0;
      off_prev     <= '0;
      tilt_reg     <= TD_W'(TILT_CENTER_RST);
      steer_reg    <= SD_W'(STEER_CENTER_RST);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TILT_CENTER:  tilt_center  <= cfg_data[TILT_DUTY_W-1:0];
          CFG_STEER_CENTER: steer_center <= cfg_data[STEER_DUTY_W-1:0];
          default: ;
        endcase
      end
      if (cmd.edge_eval && (hit_cnt != '0)) last_pos <= pos_q;
      if (cmd.tilt_mul) hist1 <= last_pos;
      if (cmd.tilt_upd) begin
        if (tilt_sum < 0)                       tilt_reg <= '0;
        else if (tilt_sum > ACC_W'(TILT_PERIOD)) tilt_reg <= TD_W'(TILT_PERIOD);
        else                                    tilt_reg <= TD_W'(tilt_sum);
      end
      if (cmd.steer_mul) off_prev <= offset;
      if (cmd.steer_upd) begin
        if (steer_raw < 0)                        steer_reg <= '0;
        else if (steer_raw > SR_W'(STEER_PERIOD)) steer_reg <= SD_W'(STEER_PERIOD);
        else                                      steer_reg <= SD_W'(steer_raw);
      end
    end
  end

  // working registers, loaded before use
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_sr <= frame_ext[NUM_SENSORS-1:0];
      weight   <= SUM_W'(NUM_SENSORS - 1);
      sum_acc  <= '0;
      hit_cnt  <= '0;
    end
    if (cmd.scan) begin
      frame_sr <= frame_sr >> 1;
      weight   <= weight - SUM_W'(2);
      if (frame_sr[0]) begin
        sum_acc <= sum_acc + weight;
        hit_cnt <= hit_cnt + 1'b1;
      end
    end
    // quotient fits QUO_W bits, so the dividend's upper part is already below the count
    if (cmd.div_init) begin
      rem <= CNT_W'(sum_mag >> QUO_W);
      quo <= sum_mag[QUO_W-1:0];
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, hit_cnt}) begin
        rem <= CNT_W'(trial - {1'b0, hit_cnt});
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= CNT_W'(trial);
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
    // loss flag held internally; the output copy moves only with the result
    if (cmd.edge_eval) lost_q <= lost_now;
    if (cmd.tilt_mul) begin
      tilt_step <= STEP_W'($signed({1'b0, tilt_gain(pos_mag)})) *
                   (STEP_W'(last_pos) - STEP_W'(hist1));
    end
    if (cmd.off_calc) begin
      offset <= OFF_W'($signed({1'b0, tilt_reg})) - OFF_W'($signed({1'b0, tilt_center}));
    end
    if (cmd.steer_mul) begin
      prod  <= PR_W'(pos_off) * PR_W'($signed({1'b0, steer_gain(pos_mag)}));
      dterm <= (DT_W'(offset) - DT_W'(off_prev)) <<< 1;
    end
    if (cmd.out_load) begin
      line_position <= LINE_POS_W'(last_pos);
      line_lost     <= lost_q;
      tilt_duty     <= TILT_DUTY_W'(tilt_reg);
      steer_duty    <= STEER_DUTY_W'(steer_reg);
    end
  end

endmodule

FILE: rtl/core/ltsc_checker.sv
// Port-level checker for the line tracking steering control, bound to the top level.
`timescale 1ns / 1ps
`include "line_tracking_steering_control_defines.svh"
module ltsc_checker import ltsc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  localparam int DUTY_W = TILT_DUTY_W + STEER_DUTY_W;

  // duties of the last delivered result; reset duties until one is delivered
  logic [DUTY_W-1:0] prev_duty;
  logic [DUTY_W-1:0] out_duty;

  assign out_duty = m_tdata[LINE_POS_W+DUTY_W-1:LINE_POS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_duty <= {STEER_DUTY_W'(STEER_CENTER_RST), TILT_DUTY_W'(TILT_CENTER_RST)};
    end else if (m_tvalid && m_tready) begin
      prev_duty <= out_duty;
    end
  end

  `LTSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `LTSC_ASSERT_NEXT(a_one_frame, s_tvalid && s_tready, !s_tready,
    "second frame taken while one is in work")
  `LTSC_ASSERT_RST(a_rst_idle, rst, !m_tvalid, "result valid right after reset")
  `LTSC_ASSERT_IMPL(a_lost_keeps, m_tvalid && m_tuser, out_duty == prev_duty,
    "duties moved on a lost line")

endmodule

bind line_tracking_steering_control ltsc_checker u_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the line tracking steering control: directed frames, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import ltsc_pkg::*;

  // run sizing
  localparam int RAND_PER_PHASE = 265;   // six phases, about 1600 frames with the directed rows
  localparam int PHASES         = 6;
  localparam int PICK_RANDOM    = -1;    // center plan entry: draw a random value
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 30;    // idle wait after the last result is back
  localparam int CYCLE_LIMIT    = 600000;

  localparam int SENSORS = NUM_SENSORS_DEF;
  localparam int TILT_MAX = TILT_PERIOD_DEF;
  localparam int STEER_MAX = STEER_PERIOD_DEF;

  typedef struct {
    logic signed [LINE_POS_W-1:0] pos;
    logic                         lost;
    logic [TILT_DUTY_W-1:0]       tilt;
    logic [STEER_DUTY_W-1:0]      steer;
  } track_result_t;

  // directed row: frame plus an optional hand-typed result
  typedef struct {
    logic [SENSOR_FRAME_W-1:0] frame;
    bit                        typed;
    track_result_t             want;
  } dir_row_t;

  // receiver stall patterns
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TILT_CENTER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  line_tracking_steering_control u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Tracker model state: own copy of centers, duties and history
  // ---------------------------------------------------------------------------
  int tilt_center_q, steer_center_q;
  int cur_pos;
  int pos_hist[2];      // [1] newest
  int off_hist[2];      // [1] newest
  int tilt_now, steer_now;

  track_result_t due_results[$];   // expected results, oldest first

  int errors, frames_sent, results_seen, lost_seen, cfg_writes;
  int burst_left;
  int cycle_cnt;
  logic hold_req = 1'b0;

  function automatic int absv(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clip(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // tilt gain by |position|
  function automatic int tilt_band(input int a);
    if (a <= 2) return 3;
    if (a <= 4) return 11;
    if (a <= 6) return 18;
    if (a <= 8) return 26;
    if (a <= 10) return 35;
    if (a <= 12) return 45;
    return 56;
  endfunction

  // steering gain by |position|
  function automatic int steer_band(input int a);
    if (a <= 4) return 6;
    if (a <= 8) return 8;
    return 10;
  endfunction

  task automatic reset_tracker();
    tilt_center_q  = TILT_CENTER_RST;
    steer_center_q = STEER_CENTER_RST;
    cur_pos        = 0;
    pos_hist       = '{0, 0};
    off_hist       = '{0, 0};
    tilt_now       = TILT_CENTER_RST;
    steer_now      = STEER_CENTER_RST;
  endtask

  // One frame through the tracker; updates state, returns the result it gives.
  function automatic track_result_t track_frame(input logic [SENSOR_FRAME_W-1:0] frame);
    int hits, wsum, p, h, off, tstep;
    bit lost;
    track_result_t r;
    hits = 0;
    wsum = 0;
    for (int i = 0; i < SENSORS; i++) begin
      if (frame[i]) begin
        hits++;
        wsum += SENSORS - 1 - 2 * i;
      end
    end
    if (hits > 0) begin
      p = wsum / hits;             // SV division truncates toward zero
      cur_pos = p;
      h = pos_hist[1];
      // near the edge and a jump across: treat as lost
      lost = (SENSORS - 1 - absv(h) <= EDGE_MARGIN) && (absv(h - p) > EDGE_DIFF_MIN) &&
             (absv(h + p) <= EDGE_SUM_MAX);
    end else begin
      p = cur_pos;
      lost = 1'b1;
    end
    if (!lost) begin
      pos_hist[0] = pos_hist[1];
      pos_hist[1] = p;
      tstep = tilt_band(absv(p)) * (pos_hist[1] - pos_hist[0]);
      off_hist[0] = off_hist[1];
      tilt_now = clip(tilt_now + tstep, TILT_MAX);
      off = tilt_now - tilt_center_q;
      off_hist[1] = off;
      steer_now = clip(steer_center_q - (p + off) * steer_band(absv(p)) -
                       2 * (off - off_hist[0]), STEER_MAX);
    end
    r.pos   = p[LINE_POS_W-1:0];
    r.lost  = lost;
    r.tilt  = tilt_now[TILT_DUTY_W-1:0];
    r.steer = steer_now[STEER_DUTY_W-1:0];
    return r;
  endfunction

  // Random frame, mostly line-like: a short run of adjacent sensors.
  function automatic logic [SENSOR_FRAME_W-1:0] random_frame();
    int width, start, f;
    case ($urandom_range(0, 9))
      0: f = 0;
      1, 2: f = $urandom;
      3, 4, 5, 6, 7: begin
        width = $urandom_range(1, 3);
        start = $urandom_range(0, SENSORS - width);
        f = ((1 << width) - 1) << start;
      end
      8: begin
        // hugging one edge
        width = $urandom_range(1, 2);
        start = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(11, 13);
        f = ((1 << width) - 1) << start;
      end
      default: f = 1 << $urandom_range(0, SENSORS - 1);
    endcase
    return f[SENSOR_FRAME_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows. Hand-typed results: reset state, far-left clip, edge loss,
  // no line. The rest sweep positions across every gain band through the model.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [26] = '{
    '{15'h0000, 1'b1, '{5'sd0, 1'b1, 10'd224, 15'd1482}},   // no line right after reset
    '{15'h0001, 1'b1, '{5'sd14, 1'b0, 10'd1000, 15'd0}},    // far left, both duties clip
    '{15'h0300, 1'b1, '{-5'sd3, 1'b1, 10'd1000, 15'd0}},    // jump off the edge: lost
    '{15'h0000, 1'b1, '{-5'sd3, 1'b1, 10'd1000, 15'd0}},    // no line, keeps last position
    '{15'h7FFF, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},        // all sensors
    '{15'h0002, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0006, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0004, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h000C, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0008, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0018, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0010, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0030, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0020, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0060, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0040, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h00C0, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0180, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0100, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h0600, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h1000, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h6000, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},
    '{15'h4000, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},        // far right
    '{15'h000B, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},        // 34/3, truncates
    '{15'h5800, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}},        // -32/3, truncates toward zero
    '{15'h4001, 1'b0, '{5'sd0, 1'b0, 10'd0, 15'd0}}         // both edges cancel
  };

  // center plan per phase, extremes first
  int tilt_plan [PHASES]  = '{0, 1000, 1000, 0, PICK_RANDOM, TILT_CENTER_RST};
  int steer_plan [PHASES] = '{0, 20000, 0, 20000, PICK_RANDOM, STEER_CENTER_RST};

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  task automatic offer_frame(input logic [SENSOR_FRAME_W-1:0] frame, input bit typed,
                             input track_result_t want);
    int gap;
    track_result_t guess;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, frame};
    do @(posedge clk); while (!s_tready);
    // request taken at this edge
    guess = track_frame(frame);
    due_results.push_back(typed ? want : guess);
    frames_sent++;
  endtask

  // sender pauses until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both center registers, back to back; only while idle
  task automatic set_centers(input int tc, input int sc);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TILT_CENTER;
    cfg_data  <= CFG_DATA_W'(tc);
    do @(posedge clk); while (!cfg_ready);
    tilt_center_q = tc;
    cfg_index <= CFG_STEER_CENTER;
    cfg_data  <= CFG_DATA_W'(sc);
    do @(posedge clk); while (!cfg_ready);
    steer_center_q = sc;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_OPEN;
  int rx_tick, hold_left;
  bit hold_done;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
        default:   m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each field against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    track_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) lost_seen++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = due_results.pop_front();
        check_field("line_position", int'(want.pos), int'($signed(m_tdata[4:0])));
        check_field("line_lost", int'(want.lost), int'(m_tuser));
        check_field("tilt_duty", int'(want.tilt), int'(m_tdata[14:5]));
        check_field("steer_duty", int'(want.steer), int'(m_tdata[29:15]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int tc, sc;
    track_result_t blank;
    blank = '{5'sd0, 1'b0, 10'd0, 15'd0};
    reset_tracker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows on the reset centers
    foreach (dir_rows[k]) offer_frame(dir_rows[k].frame, dir_rows[k].typed, dir_rows[k].want);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      tc = (tilt_plan[ph] == PICK_RANDOM) ? $urandom_range(0, TILT_MAX) : tilt_plan[ph];
      sc = (steer_plan[ph] == PICK_RANDOM) ? $urandom_range(0, STEER_MAX) : steer_plan[ph];
      set_centers(tc, sc);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // receiver goes quiet while frames keep coming: input must back up
        if (ph == 2 && n == 100) hold_req <= 1'b1;
        offer_frame(random_frame(), 1'b0, blank);
      end
      settle();
    end

    $display("Covered %0d frames over %0d center settings, %0d register writes,",
             frames_sent, PHASES + 1, cfg_writes);
    $display("%0d results checked, %0d of them with the line lost", results_seen, lost_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
